@@ hdl/lli_pkg.sv @@
// Shared widths, constants and types for the two-line intersection block.
package lli_pkg;

	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 16;
	localparam int IN_W       = 16;
	localparam int OUT_W      = 48;
	localparam int N_IN       = 8;

	localparam int AB   = COORD_BITS + 1;
	localparam int CPB  = 2 * COORD_BITS;
	localparam int CW   = CPB + 1;
	localparam int DPB  = 2 * AB;
	localparam int DW   = DPB + 1;
	localparam int NPB  = AB + CW;
	localparam int NW   = NPB + 1;
	localparam int QW   = NW + FRAC_BITS;
	localparam int CMPW = ((QW > OUT_W) ? QW : OUT_W) + 1;

	localparam int S_DATA_W = N_IN * IN_W;
	localparam int M_DATA_W = 2 * OUT_W;
	localparam int M_USER_W = 2;

	localparam int USER_PAR  = 0;
	localparam int USER_CLIP = 1;

	typedef struct packed {
		logic          valid;
		logic          par;
		logic          neg_x;
		logic          neg_y;
		logic [NW-1:0] mag_x;
		logic [NW-1:0] mag_y;
		logic [DW-1:0] dmag;
	} front_out_t;

endpackage

@@ hdl/lli_front.sv @@
// Front pipeline: line coefficients, determinant, numerators, sign and magnitude.
module lli_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [lli_pkg::S_DATA_W-1:0] in_data,
	output lli_pkg::front_out_t          fo
);

	localparam int CB  = lli_pkg::COORD_BITS;
	localparam int IW  = lli_pkg::IN_W;
	localparam int AB  = lli_pkg::AB;
	localparam int CPB = lli_pkg::CPB;
	localparam int CW  = lli_pkg::CW;
	localparam int DPB = lli_pkg::DPB;
	localparam int DW  = lli_pkg::DW;
	localparam int NPB = lli_pkg::NPB;
	localparam int NW  = lli_pkg::NW;

	logic signed [CB-1:0] x1, y1, x2, y2, x3, y3, x4, y4;

	assign x1 = signed'(in_data[0*IW +: CB]);
	assign y1 = signed'(in_data[1*IW +: CB]);
	assign x2 = signed'(in_data[2*IW +: CB]);
	assign y2 = signed'(in_data[3*IW +: CB]);
	assign x3 = signed'(in_data[4*IW +: CB]);
	assign y3 = signed'(in_data[5*IW +: CB]);
	assign x4 = signed'(in_data[6*IW +: CB]);
	assign y4 = signed'(in_data[7*IW +: CB]);

	// stage 1: a, b and the cross products for c
	logic                  v_s1, v_s2, v_s3, v_s4;
	logic signed [AB-1:0]  a1_s1, b1_s1, a2_s1, b2_s1;
	logic signed [CPB-1:0] p21_s1, p12_s1, p43_s1, p34_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a1_s1  <= AB'(y2) - AB'(y1);
			b1_s1  <= AB'(x1) - AB'(x2);
			a2_s1  <= AB'(y4) - AB'(y3);
			b2_s1  <= AB'(x3) - AB'(x4);
			p21_s1 <= CPB'(x2) * CPB'(y1);
			p12_s1 <= CPB'(x1) * CPB'(y2);
			p43_s1 <= CPB'(x4) * CPB'(y3);
			p34_s1 <= CPB'(x3) * CPB'(y4);
		end
	end

	// stage 2: c and the determinant products
	logic signed [AB-1:0]  a1_s2, b1_s2, a2_s2, b2_s2;
	logic signed [CW-1:0]  c1_s2, c2_s2;
	logic signed [DPB-1:0] pd1_s2, pd2_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			a1_s2  <= a1_s1;
			b1_s2  <= b1_s1;
			a2_s2  <= a2_s1;
			b2_s2  <= b2_s1;
			c1_s2  <= CW'(p21_s1) - CW'(p12_s1);
			c2_s2  <= CW'(p43_s1) - CW'(p34_s1);
			pd1_s2 <= DPB'(a1_s1) * DPB'(b2_s1);
			pd2_s2 <= DPB'(a2_s1) * DPB'(b1_s1);
		end
	end

	// stage 3: determinant and the numerator products
	logic signed [DW-1:0]  det_s3;
	logic signed [NPB-1:0] px1_s3, px2_s3, py1_s3, py2_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			det_s3 <= DW'(pd1_s2) - DW'(pd2_s2);
			px1_s3 <= NPB'(b1_s2) * NPB'(c2_s2);
			px2_s3 <= NPB'(b2_s2) * NPB'(c1_s2);
			py1_s3 <= NPB'(a2_s2) * NPB'(c1_s2);
			py2_s3 <= NPB'(a1_s2) * NPB'(c2_s2);
		end
	end

	// stage 4: numerators, then split into sign and magnitude for the dividers
	logic signed [NW-1:0] numx, numy;
	logic                 par_s4, negx_s4, negy_s4;
	logic [NW-1:0]        magx_s4, magy_s4;
	logic [DW-1:0]        dmag_s4;

	assign numx = NW'(px1_s3) - NW'(px2_s3);
	assign numy = NW'(py1_s3) - NW'(py2_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			par_s4  <= (det_s3 == '0);
			negx_s4 <= numx[NW-1] ^ det_s3[DW-1];
			negy_s4 <= numy[NW-1] ^ det_s3[DW-1];
			magx_s4 <= numx[NW-1] ? NW'(-numx) : NW'(numx);
			magy_s4 <= numy[NW-1] ? NW'(-numy) : NW'(numy);
			dmag_s4 <= det_s3[DW-1] ? DW'(-det_s3) : DW'(det_s3);
		end
	end

	assign fo = {v_s4, par_s4, negx_s4, negy_s4, magx_s4, magy_s4, dmag_s4};

endmodule

@@ hdl/lli_div.sv @@
// Restoring divider, one quotient bit per pipeline stage.
module lli_div (
	input  logic                   clk,
	input  logic                   en,
	input  logic [lli_pkg::NW-1:0] num,
	input  logic [lli_pkg::DW-1:0] den,
	output logic [lli_pkg::QW-1:0] quo
);

	localparam int QW = lli_pkg::QW;
	localparam int DW = lli_pkg::DW;

	logic [DW-1:0] rem_s [QW];
	logic [QW-1:0] num_s [QW];
	logic [QW-1:0] quo_s [QW];
	logic [DW-1:0] den_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DW-1:0] r_in, r_nx, d_in;
		logic [QW-1:0] n_in, q_in;
		logic [DW:0]   trial;
		logic          ge;

		if (k == 0) begin : g_first
			assign r_in = '0;
			assign n_in = QW'(num) << lli_pkg::FRAC_BITS;
			assign q_in = '0;
			assign d_in = den;
		end else begin : g_next
			assign r_in = rem_s[k-1];
			assign n_in = num_s[k-1];
			assign q_in = quo_s[k-1];
			assign d_in = den_s[k-1];
		end

		assign trial = {r_in, n_in[QW-1]};
		assign ge    = (trial >= {1'b0, d_in});
		assign r_nx  = ge ? DW'(trial - {1'b0, d_in}) : DW'(trial);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= r_nx;
				num_s[k] <= n_in << 1;
				quo_s[k] <= {q_in[QW-2:0], ge};
				den_s[k] <= d_in;
			end
		end
	end

	assign quo = quo_s[QW-1];

endmodule

@@ hdl/line_line_intersection_2d_top.sv @@
// Top level of the two-line intersection block: front pipeline, dividers, output register.
//
// Takes two lines, each as two points with signed integer coordinates, and returns
// their intersection by Cramer's rule as signed fixed point with 16 fraction bits,
// truncated toward zero. One line pair enters per clock while the output is not stalled;
// results leave in order through four arithmetic stages, one divider stage per quotient
// bit and one output register. Parallel or coincident lines, including a line
// whose two points coincide, give the point (0,0) with is_parallel set. A quotient
// outside the 48-bit range saturates and sets clipped. The whole pipeline advances
// together whenever the output register is empty or being taken, so a stall at the
// output holds every stage and drops nothing.
module line_line_intersection_2d_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// line_a_p1_x, line_a_p1_y, line_a_p2_x, line_a_p2_y,
	// line_b_p1_x, line_b_p1_y, line_b_p2_x, line_b_p2_y (16 bits each)
	input  logic [lli_pkg::S_DATA_W-1:0] s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// cross_x [47:0], cross_y [95:48]
	output logic [lli_pkg::M_DATA_W-1:0] m_tdata,
	// is_parallel [0], clipped [1]
	output logic [lli_pkg::M_USER_W-1:0] m_tuser
);

	localparam int QW   = lli_pkg::QW;
	localparam int OW   = lli_pkg::OUT_W;
	localparam int CMPW = lli_pkg::CMPW;

	logic               en;
	lli_pkg::front_out_t fo;
	logic [QW-1:0]      qx, qy;

	// advance everything when the output word is gone or leaving now
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	lli_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_tvalid),
		.in_data  (s_tdata),
		.fo       (fo)
	);

	lli_div u_div_x (
		.clk (clk),
		.en  (en),
		.num (fo.mag_x),
		.den (fo.dmag),
		.quo (qx)
	);

	lli_div u_div_y (
		.clk (clk),
		.en  (en),
		.num (fo.mag_y),
		.den (fo.dmag),
		.quo (qy)
	);

	// sideband that rides beside the divider stages
	logic valid_d_s [QW];
	logic par_d_s   [QW];
	logic negx_d_s  [QW];
	logic negy_d_s  [QW];

	for (genvar k = 0; k < QW; k++) begin : g_side
		logic vi, pi, nxi, nyi;
		if (k == 0) begin : g_first
			assign vi  = fo.valid;
			assign pi  = fo.par;
			assign nxi = fo.neg_x;
			assign nyi = fo.neg_y;
		end else begin : g_next
			assign vi  = valid_d_s[k-1];
			assign pi  = par_d_s[k-1];
			assign nxi = negx_d_s[k-1];
			assign nyi = negy_d_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_d_s[k] <= 1'b0;
			end else if (en) begin
				valid_d_s[k] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				par_d_s[k]  <= pi;
				negx_d_s[k] <= nxi;
				negy_d_s[k] <= nyi;
			end
		end
	end

	// saturate to the output range and restore the sign
	logic [CMPW-1:0] lim_x, lim_y;
	logic            clip_x, clip_y;
	logic [OW-1:0]   val_x, val_y, out_x, out_y;
	logic            par_o;

	assign par_o  = par_d_s[QW-1];
	assign lim_x  = (CMPW'(1) << (OW - 1)) - (negx_d_s[QW-1] ? CMPW'(0) : CMPW'(1));
	assign lim_y  = (CMPW'(1) << (OW - 1)) - (negy_d_s[QW-1] ? CMPW'(0) : CMPW'(1));
	assign clip_x = CMPW'(qx) > lim_x;
	assign clip_y = CMPW'(qy) > lim_y;
	assign val_x  = clip_x ? lim_x[OW-1:0] : OW'(qx);
	assign val_y  = clip_y ? lim_y[OW-1:0] : OW'(qy);
	assign out_x  = negx_d_s[QW-1] ? OW'(-val_x) : val_x;
	assign out_y  = negy_d_s[QW-1] ? OW'(-val_y) : val_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= valid_d_s[QW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata                    <= par_o ? '0 : {out_y, out_x};
			m_tuser[lli_pkg::USER_PAR]  <= par_o;
			m_tuser[lli_pkg::USER_CLIP] <= !par_o && (clip_x || clip_y);
		end
	end

endmodule

@@ hdl/lli_chk.sv @@
// Port-level checker for the two-line intersection block, bound to the top level.
module lli_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [lli_pkg::M_DATA_W-1:0] m_tdata,
	input logic [lli_pkg::M_USER_W-1:0] m_tuser
);

	localparam int OW = lli_pkg::OUT_W;

	logic [OW-1:0] max_v, min_v;
	assign max_v = (OW'(1) << (OW - 1)) - OW'(1);
	assign min_v = OW'(1) << (OW - 1);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output word changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	a_par: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[lli_pkg::USER_PAR] |->
			m_tdata == '0 && !m_tuser[lli_pkg::USER_CLIP])
		else $error("parallel result not zero or flagged clipped");

	a_clip: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[lli_pkg::USER_CLIP] |->
			m_tdata[OW-1:0] == max_v || m_tdata[OW-1:0] == min_v ||
			m_tdata[2*OW-1:OW] == max_v || m_tdata[2*OW-1:OW] == min_v)
		else $error("clipped result not at a range limit");

endmodule

bind line_line_intersection_2d_top lli_chk u_lli_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
